### rtl/iir_direct_form_filter_defines.svh
// assertion macros for the iir direct form filter
// no dependencies; included by files that carry checks
`ifndef IIR_DIRECT_FORM_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_FILTER_DEFINES_SVH

// same-cycle implication
`define IIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iir check failed");

// next-cycle implication
`define IIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iir check failed");

`endif

### rtl/iir_pkg.sv
// shared types and constants for the iir direct form filter
// no dependencies
package iir_pkg;

  localparam int ACC_BITS      = 64;
  localparam int FRAC_BITS     = 5;
  localparam int ORDER_BITS    = 5;
  localparam int OP_BITS       = 2;
  localparam int COEF_IDX_BITS = 5;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [ORDER_BITS-1:0] ORDER_RST = 5'd2;
  localparam logic [FRAC_BITS-1:0]  FRAC_RST  = 5'd24;

  typedef enum logic [OP_BITS-1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORDER = 4'd0,
    CFG_FRAC  = 4'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_RND,
    S_SHR,
    S_SAT
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic sub;
    logic rnd;
    logic shr;
  } mac_ctrl_t;

endpackage

### rtl/iir_coef_store.sv
// feed-forward and feedback coefficient tables
// depends on iir_pkg
module iir_coef_store #(
  parameter int MAX_ORDER  = 16,
  parameter int COEFF_BITS = 32,
  parameter int IW         = $clog2(MAX_ORDER + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic                                 wr_side,
  input  logic [iir_pkg::COEF_IDX_BITS-1:0]    wr_idx,
  input  logic signed [COEFF_BITS-1:0]         wr_data,
  input  logic                                 rd_side,
  input  logic [IW-1:0]                        rd_idx,
  output logic signed [COEFF_BITS-1:0]         rd_data
);

  logic signed [COEFF_BITS-1:0] b_r [0:MAX_ORDER];
  logic signed [COEFF_BITS-1:0] a_r [0:MAX_ORDER];
  logic                         idx_ok;

  assign idx_ok = (32'(wr_idx) <= MAX_ORDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        b_r[i] <= '0;
        a_r[i] <= '0;
      end
    end else if (wr_en && idx_ok) begin
      if (!wr_side) begin
        b_r[IW'(wr_idx)] <= wr_data;
      end else if (wr_idx != '0) begin
        a_r[IW'(wr_idx)] <= wr_data;
      end
    end
  end

  assign rd_data = rd_side ? a_r[rd_idx] : b_r[rd_idx];

endmodule

### rtl/iir_hist.sv
// input and output sample history shift lines
// no dependencies; parameters are set by the top level
module iir_hist #(
  parameter int MAX_ORDER   = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int IW          = $clog2(MAX_ORDER + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          push_x,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  logic                          push_y,
  input  logic signed [SAMPLE_BITS-1:0] y_in,
  input  logic                          rd_side,
  input  logic [IW-1:0]                 rd_idx,
  output logic signed [SAMPLE_BITS-1:0] rd_data
);

  localparam int YW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic signed [SAMPLE_BITS-1:0] x_r [0:MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] y_r [0:MAX_ORDER-1];
  logic [IW-1:0]                 y_idx;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        x_r[i] <= '0;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        y_r[i] <= '0;
      end
    end else begin
      if (push_x) begin
        for (int i = MAX_ORDER; i > 0; i--) begin
          x_r[i] <= x_r[i-1];
        end
        x_r[0] <= x_in;
      end
      if (push_y) begin
        for (int i = MAX_ORDER - 1; i > 0; i--) begin
          y_r[i] <= y_r[i-1];
        end
        y_r[0] <= y_in;
      end
    end
  end

  // feedback tap i reads output i-1
  assign y_idx   = rd_idx - IW'(1);
  assign rd_data = rd_side ? y_r[YW'(y_idx)] : x_r[rd_idx];

endmodule

### rtl/iir_mac.sv
// shared multiply-accumulate with rounding shift and saturation
// depends on iir_pkg
module iir_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  iir_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [COEFF_BITS-1:0]       coef,
  input  logic signed [SAMPLE_BITS-1:0]      samp,
  input  logic [iir_pkg::FRAC_BITS-1:0]      frac,
  output logic signed [SAMPLE_BITS-1:0]      result,
  output logic                               sat
);

  localparam int PW = COEFF_BITS + SAMPLE_BITS;
  localparam int AW = iir_pkg::ACC_BITS;
  localparam logic signed [AW-1:0] MAXV = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
  localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);

  logic signed [PW-1:0] prod_r;
  logic                 prod_v_r;
  logic                 prod_sub_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] prod_ext;
  logic                 over;
  logic                 under;

  assign prod_ext = AW'(prod_r);

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= coef * samp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r   <= 1'b0;
      prod_sub_r <= 1'b0;
    end else begin
      prod_v_r   <= ctrl.mul;
      prod_sub_r <= ctrl.sub;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= prod_sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end else if (ctrl.rnd && (frac != '0)) begin
      acc_r <= acc_r + (AW'(1) << (frac - iir_pkg::FRAC_BITS'(1)));
    end else if (ctrl.shr) begin
      acc_r <= acc_r >>> frac;
    end
  end

  assign over  = (acc_r > MAXV);
  assign under = (acc_r < MINV);
  assign sat   = over || under;

  always_comb begin
    priority if (over) begin
      result = MAXV[SAMPLE_BITS-1:0];
    end else if (under) begin
      result = MINV[SAMPLE_BITS-1:0];
    end else begin
      result = acc_r[SAMPLE_BITS-1:0];
    end
  end

endmodule

### rtl/iir_direct_form_filter.sv
// channel  | signals                                               | role
// in       | in_valid in_ready in_op in_sample_in in_coeff_*       | sample, coef write, clear
// out      | out_valid out_ready out_sample_out out_saturated      | one beat per sample
// cfg      | cfg_valid cfg_ready cfg_index cfg_data                | order and fraction bits
// a sample beat runs these steps before the next beat is accepted, K the order in use:
// one multiply-accumulate per tap (K+1 feed-forward, K feedback), then drain, round,
// shift and saturate; the single shared multiplier takes the taps in turn
// coefficient write and clear beats are done in idle and do not leave it
// reset is synchronous and clears histories, coefficients, configuration and control state
// a result waits in the output register; the next sample stalls in saturate until it is taken
// top level of the iir direct form filter; depends on iir_pkg, iir_coef_store,
// iir_hist, iir_mac and iir_direct_form_filter_defines.svh
`include "iir_direct_form_filter_defines.svh"

module iir_direct_form_filter #(
  parameter int MAX_ORDER   = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [iir_pkg::OP_BITS-1:0]          in_op,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  input  logic                                 in_coeff_side,
  input  logic [iir_pkg::COEF_IDX_BITS-1:0]    in_coeff_index,
  input  logic signed [COEFF_BITS-1:0]         in_coeff_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iir_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [iir_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int IW = $clog2(MAX_ORDER + 1);

  iir_pkg::state_t                  state_r, state_nxt;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic                             phase_r, phase_nxt;
  logic [iir_pkg::ORDER_BITS-1:0]   order_r;
  logic [iir_pkg::FRAC_BITS-1:0]    frac_r;
  logic                             out_valid_r;
  logic signed [SAMPLE_BITS-1:0]    out_sample_r;
  logic                             out_sat_r;
  logic [IW-1:0]                    k_eff;
  iir_pkg::mac_ctrl_t               ctrl;
  logic                             coef_we;
  logic                             hist_clr;
  logic                             push_x;
  logic                             load_out;
  logic signed [COEFF_BITS-1:0]     coef_rd;
  logic signed [SAMPLE_BITS-1:0]    hist_rd;
  logic signed [SAMPLE_BITS-1:0]    mac_result;
  logic                             mac_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= iir_pkg::ORDER_RST;
      frac_r  <= iir_pkg::FRAC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (iir_pkg::cfg_idx_t'(cfg_index))
        iir_pkg::CFG_ORDER: order_r <= cfg_data[iir_pkg::ORDER_BITS-1:0];
        iir_pkg::CFG_FRAC:  frac_r  <= cfg_data[iir_pkg::FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // order clamped to 1..MAX_ORDER
  always_comb begin
    priority if (order_r == '0) begin
      k_eff = IW'(1);
    end else if (32'(order_r) > MAX_ORDER) begin
      k_eff = IW'(MAX_ORDER);
    end else begin
      k_eff = IW'(order_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iir_pkg::S_IDLE;
      idx_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    coef_we   = 1'b0;
    hist_clr  = 1'b0;
    push_x    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      iir_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (iir_pkg::op_t'(in_op))
            iir_pkg::OP_SAMPLE: begin
              push_x    = 1'b1;
              ctrl.clr  = 1'b1;
              idx_nxt   = '0;
              phase_nxt = 1'b0;
              state_nxt = iir_pkg::S_MAC;
            end
            iir_pkg::OP_COEF:  coef_we  = 1'b1;
            iir_pkg::OP_CLEAR: hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      iir_pkg::S_MAC: begin
        ctrl.mul = 1'b1;
        ctrl.sub = phase_r;
        if (idx_r == k_eff) begin
          if (phase_r) begin
            state_nxt = iir_pkg::S_DRAIN;
          end else begin
            phase_nxt = 1'b1;
            idx_nxt   = IW'(1);
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      iir_pkg::S_DRAIN: state_nxt = iir_pkg::S_RND;
      iir_pkg::S_RND: begin
        ctrl.rnd  = 1'b1;
        state_nxt = iir_pkg::S_SHR;
      end
      iir_pkg::S_SHR: begin
        ctrl.shr  = 1'b1;
        state_nxt = iir_pkg::S_SAT;
      end
      iir_pkg::S_SAT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = iir_pkg::S_IDLE;
        end
      end
      default: state_nxt = iir_pkg::S_IDLE;
    endcase
  end

  iir_coef_store #(
    .MAX_ORDER  (MAX_ORDER),
    .COEFF_BITS (COEFF_BITS),
    .IW         (IW)
  ) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_we),
    .wr_side (in_coeff_side),
    .wr_idx  (in_coeff_index),
    .wr_data (in_coeff_value),
    .rd_side (phase_r),
    .rd_idx  (idx_r),
    .rd_data (coef_rd)
  );

  iir_hist #(
    .MAX_ORDER   (MAX_ORDER),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IW          (IW)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (hist_clr),
    .push_x  (push_x),
    .x_in    (in_sample_in),
    .push_y  (load_out),
    .y_in    (mac_result),
    .rd_side (phase_r),
    .rd_idx  (idx_r),
    .rd_data (hist_rd)
  );

  iir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .coef   (coef_rd),
    .samp   (hist_rd),
    .frac   (frac_r),
    .result (mac_result),
    .sat    (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= mac_result;
      out_sat_r    <= mac_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  `IIR_ASSERT_IMP(a_tap_bound, clk, rst_n, state_r == iir_pkg::S_MAC, idx_r <= k_eff)
  `IIR_ASSERT_IMP(a_fb_skips_a0, clk, rst_n,
                  state_r == iir_pkg::S_MAC && phase_r, idx_r != '0)
  `IIR_ASSERT_NXT(a_sample_starts, clk, rst_n,
                  in_valid && in_ready && in_op == iir_pkg::OP_SAMPLE,
                  state_r == iir_pkg::S_MAC && idx_r == '0 && !phase_r)
  `IIR_ASSERT_IMP(a_out_from_sat, clk, rst_n,
                  $rose(out_valid_r), $past(state_r) == iir_pkg::S_SAT)

endmodule
